// ----- rtl/core/gdn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_pkg
// Shared types, constants and calendar tables for the day number converter.
// ----------------------------------------------------------------------------
package gdn_pkg;

    localparam int MAX_YEAR       = 9999;
    // day number of december 31 of the last supported year
    localparam int MAX_DAY_NUMBER = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                    + MAX_YEAR / 400;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int DN_W      = 22;
    localparam int WD_W      = 3;
    localparam int DOY_W     = 9;
    localparam int BIT_W     = 3;
    localparam int Q100_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // p / 100 as (p * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit p
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;

    localparam logic [DN_W-1:0] DAYS_400 = 22'd146097;
    localparam logic [DN_W-1:0] DAYS_100 = 22'd36524;
    localparam logic [DN_W-1:0] DAYS_4   = 22'd1461;
    localparam logic [DN_W-1:0] DAYS_1   = 22'd365;

    typedef enum logic {
        OP_TO_DAY_NUMBER = 1'b0,
        OP_TO_DATE       = 1'b1
    } gdn_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK_DN,
        ST_DIV,
        ST_MONTH,
        ST_DAY,
        ST_YR_RECIP,
        ST_YR_BASE,
        ST_YR_SUM,
        ST_WEEKDAY,
        ST_OUT
    } gdn_state_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_CHECK_DN,
        STEP_DIV,
        STEP_MONTH,
        STEP_DAY,
        STEP_YR_RECIP,
        STEP_YR_BASE,
        STEP_YR_SUM,
        STEP_WEEKDAY
    } gdn_step_t;

    typedef enum logic [1:0] {
        DIV_400,
        DIV_100,
        DIV_4,
        DIV_1
    } gdn_div_sel_t;

    typedef struct packed {
        logic             load;
        gdn_step_t        step;
        gdn_div_sel_t     div_sel;
        logic [BIT_W-1:0] bit_idx;
        logic             out_load;
    } gdn_cmd_t;

    typedef struct packed {
        logic err;
    } gdn_status_t;

    // highest quotient bit of each cycle division
    function automatic logic [BIT_W-1:0] div_top_bit(input gdn_div_sel_t sel);
        logic [BIT_W-1:0] b;
        unique case (sel)
            DIV_100, DIV_1: b = 3'd1;
            default:        b = 3'd4;
        endcase
        return b;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        unique case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // days of a common year before the first of the month
    function automatic logic [DOY_W-1:0] cum_before(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] n;
        unique case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // 8 is 1 mod 7, so octal digits fold
    function automatic logic [WD_W-1:0] mod7(input logic [DN_W-1:0] v);
        logic [23:0] w;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [3:0]  s3;
        w  = {2'b00, v};
        s1 = 6'd0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 6'(w[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

endpackage

// ----- rtl/core/gdn_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_ctrl
// Sequencer: walks one item through the conversion steps and holds the
// result handshake.
// ----------------------------------------------------------------------------
module gdn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_op,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  gdn_pkg::gdn_status_t status,
    output gdn_pkg::gdn_cmd_t    cmd
);
    import gdn_pkg::*;

    gdn_state_t       state_reg, state_next;
    gdn_div_sel_t     div_sel_reg, div_sel_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (gdn_op_t'(s_op) == OP_TO_DATE) ? ST_CHECK_DN : ST_YR_RECIP;
                end
            end
            ST_CHECK_DN: state_next = ST_DIV;
            ST_DIV: begin
                if (status.err) begin
                    state_next = ST_OUT;
                end else if (bit_reg == '0 && div_sel_reg == DIV_1) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:    state_next = ST_DAY;
            ST_DAY:      state_next = ST_WEEKDAY;
            ST_YR_RECIP: state_next = ST_YR_BASE;
            ST_YR_BASE:  state_next = ST_YR_SUM;
            ST_YR_SUM:   state_next = status.err ? ST_OUT : ST_WEEKDAY;
            ST_WEEKDAY:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // division sequence counters
    always_comb begin
        div_sel_next = div_sel_reg;
        bit_next     = bit_reg;
        if (state_reg == ST_IDLE) begin
            div_sel_next = DIV_400;
            bit_next     = div_top_bit(DIV_400);
        end else if (state_reg == ST_DIV) begin
            if (bit_reg != '0) begin
                bit_next = bit_reg - 3'd1;
            end else if (div_sel_reg != DIV_1) begin
                div_sel_next = gdn_div_sel_t'(div_sel_reg + 2'd1);
                bit_next     = div_top_bit(gdn_div_sel_t'(div_sel_reg + 2'd1));
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (state_reg == ST_OUT && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.step     = STEP_NONE;
        cmd.div_sel  = div_sel_reg;
        cmd.bit_idx  = bit_reg;
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.out_load = (state_reg == ST_OUT) && out_free;
        unique case (state_reg)
            ST_CHECK_DN: cmd.step = STEP_CHECK_DN;
            ST_DIV:      cmd.step = STEP_DIV;
            ST_MONTH:    cmd.step = STEP_MONTH;
            ST_DAY:      cmd.step = STEP_DAY;
            ST_YR_RECIP: cmd.step = STEP_YR_RECIP;
            ST_YR_BASE:  cmd.step = STEP_YR_BASE;
            ST_YR_SUM:   cmd.step = STEP_YR_SUM;
            ST_WEEKDAY:  cmd.step = STEP_WEEKDAY;
            default:     cmd.step = STEP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            div_sel_reg  <= DIV_400;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_sel_reg  <= div_sel_next;
            bit_reg      <= bit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- rtl/core/gdn_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_dp
// Datapath: input capture, cycle division by restoring steps, month and
// weekday decode, day number accumulation and the result register.
// ----------------------------------------------------------------------------
module gdn_dp (
    input  logic                             aclk,
    input  gdn_pkg::gdn_cmd_t                cmd,
    input  logic [gdn_pkg::S_TDATA_W-1:0]    s_tdata,
    output gdn_pkg::gdn_status_t             status,
    output logic [gdn_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser
);
    import gdn_pkg::*;

    logic [YEAR_W-1:0]  year_in_reg;
    logic [MONTH_W-1:0] month_in_reg;
    logic [DAY_W-1:0]   day_in_reg;
    logic [DN_W-1:0]    dn_in_reg;

    logic [DN_W-1:0]    rem_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [DN_W-1:0]    rn_reg;
    logic [WD_W-1:0]    wd_reg;
    logic               err_reg;
    logic               leap_reg;
    logic [1:0]         c100_reg;
    logic [4:0]         c4_reg;
    logic [1:0]         c1_reg;
    logic [Q100_W-1:0]  q100_reg;
    logic [DN_W-1:0]    dby_reg;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // division step
    logic [DN_W-1:0]   d_base, d_shift;
    logic [YEAR_W-1:0] w_base, w_shift;
    logic              take;

    // year base (date to day number)
    logic [YEAR_W-1:0] p;
    logic [PROD_W-1:0] prod;
    logic [22:0]       p365;
    logic [YEAR_W-1:0] rem100;
    logic              leap_y;
    logic              date_ok;

    // month decode (day number to date)
    logic              leap_c;
    logic [DOY_W-1:0]  doy;
    logic [MONTH_W-1:0] month_cnt;

    always_comb begin
        unique case (cmd.div_sel)
            DIV_400: begin d_base = DAYS_400; w_base = 14'd400; end
            DIV_100: begin d_base = DAYS_100; w_base = 14'd100; end
            DIV_4:   begin d_base = DAYS_4;   w_base = 14'd4;   end
            default: begin d_base = DAYS_1;   w_base = 14'd1;   end
        endcase
        d_shift = d_base << cmd.bit_idx;
        w_shift = w_base << cmd.bit_idx;
        take    = (rem_reg >= d_shift);
    end

    always_comb begin
        p      = year_in_reg - 14'd1;
        prod   = PROD_W'(p) * PROD_W'(RECIP_100);
        p365   = 23'(p) * 23'd365;
        rem100 = p - 14'(q100_reg) * 14'd100;
        // y is a multiple of 400 exactly when p mod 100 is 99 and p / 100 is 3 mod 4
        leap_y = (year_in_reg[1:0] == 2'd0)
                 && ((rem100 != 14'd99) || (q100_reg[1:0] == 2'd3));
        date_ok = (year_in_reg != '0) && (32'(year_in_reg) <= MAX_YEAR)
                  && (month_in_reg != '0) && (month_in_reg <= 4'd12)
                  && (day_in_reg != '0) && (day_in_reg <= month_len(month_in_reg, leap_y));
    end

    always_comb begin
        // leap when last year of a 4-year block, unless it closes a common century
        leap_c    = (c1_reg == 2'd3) && ((c4_reg != 5'd24) || (c100_reg == 2'd3));
        doy       = rem_reg[DOY_W-1:0] + 9'd1;
        month_cnt = 4'd1;
        for (int m = 1; m < 12; m++) begin
            if (doy > cum_before(4'(m + 1)) + 9'((leap_c && m >= 2) ? 1 : 0)) begin
                month_cnt = month_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_in_reg  <= s_tdata[13:0];
            month_in_reg <= s_tdata[17:14];
            day_in_reg   <= s_tdata[22:18];
            dn_in_reg    <= s_tdata[44:23];
            year_reg     <= '0;
            c100_reg     <= '0;
            c4_reg       <= '0;
            c1_reg       <= '0;
            err_reg      <= 1'b0;
        end else begin
            case (cmd.step)
                STEP_CHECK_DN: begin
                    rem_reg <= dn_in_reg - 22'd1;
                    rn_reg  <= dn_in_reg;
                    err_reg <= (dn_in_reg == '0) || (32'(dn_in_reg) > MAX_DAY_NUMBER);
                end
                STEP_DIV: begin
                    if (take) begin
                        rem_reg  <= rem_reg - d_shift;
                        year_reg <= year_reg + w_shift;
                        case (cmd.div_sel)
                            DIV_100: c100_reg[cmd.bit_idx[0]] <= 1'b1;
                            DIV_4:   c4_reg[cmd.bit_idx]      <= 1'b1;
                            DIV_1:   c1_reg[cmd.bit_idx[0]]   <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                STEP_MONTH: begin
                    year_reg  <= year_reg + 14'd1;
                    leap_reg  <= leap_c;
                    month_reg <= month_cnt;
                    rem_reg   <= DN_W'(doy);
                end
                STEP_DAY: begin
                    day_reg <= DAY_W'(rem_reg[DOY_W-1:0] - cum_before(month_reg)
                                      - 9'((leap_reg && month_reg > 4'd2) ? 1 : 0));
                end
                STEP_YR_RECIP: begin
                    q100_reg <= prod[RECIP_SHIFT +: Q100_W];
                end
                STEP_YR_BASE: begin
                    dby_reg   <= DN_W'(p365 + 23'(p >> 2) - 23'(q100_reg)
                                       + 23'(q100_reg >> 2));
                    leap_reg  <= leap_y;
                    err_reg   <= !date_ok;
                    year_reg  <= year_in_reg;
                    month_reg <= month_in_reg;
                    day_reg   <= day_in_reg;
                end
                STEP_YR_SUM: begin
                    rn_reg <= dby_reg + DN_W'(cum_before(month_reg))
                              + DN_W'((leap_reg && month_reg > 4'd2) ? 1 : 0)
                              + DN_W'(day_reg);
                end
                STEP_WEEKDAY: begin
                    wd_reg <= mod7(rn_reg);
                end
                default: ;
            endcase
        end
    end

    // result register, all zero on a range error
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= err_reg;
            if (err_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {wd_reg, rn_reg, day_reg, month_reg, year_reg};
            end
        end
    end

    assign status.err = err_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser    = m_tuser_reg;

endmodule

// ----- rtl/core/gregorian_day_number_converter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_top
// Proleptic Gregorian date to day number converter and its inverse.
// ----------------------------------------------------------------------------
// One item is processed at a time. A date to day number item (op 0) passes
// through a reciprocal multiply for year / 100, the year base and range
// check, the month sum, and the weekday fold. A day number to date item
// (op 1) runs the restoring divider that strips 400, 100, 4 and 1 year
// cycles one quotient bit per cycle (14 steps), followed by month and day
// decode and the weekday fold. A range error on op 1 skips the division.
// The next item is taken as soon as the result sits in the output register,
// even while it waits for m_tready. Results with range_error set carry
// all-zero data.
module gregorian_day_number_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_year, in_month, in_day, in_day_number, zero pad
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_year, out_month, out_day, out_day_number, weekday
    output logic [0:0]  m_tuser    // range_error
);
    import gdn_pkg::*;

    gdn_cmd_t    cmd;
    gdn_status_t status;

    gdn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdn_dp u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser[0])
    );

    // one item in flight: acceptance drops ready
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("range error result carries data");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:45] != 3'd7)
        else $error("weekday out of range");

    a_valid_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[17:14] != 4'd0 && m_tdata[22:18] != 5'd0)
        else $error("valid result with zero month or day");

endmodule

// ----- tb/sv/gdn_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_result_checker
// Watches both stream channels of the day number converter, computes the
// expected date, day number, weekday and range flag for every accepted input
// transaction and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
module gdn_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // in_year, in_month, in_day, in_day_number, zero pad
    input  logic [0:0]  s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // out_year, out_month, out_day, out_day_number, weekday
    input  logic [0:0]  m_tuser,   // range_error
    output int          failures,
    output int          pending
);
    import gdn_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DN_W-1:0]    day_number;
        logic [WD_W-1:0]    weekday;
        logic               range_error;
    } calendar_result_t;

    calendar_result_t expected_dates[$];
    int               mismatch_count = 0;

    assign failures = mismatch_count;
    assign pending  = expected_dates.size();

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = is_leap(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // days in all years before year y
    function automatic int unsigned days_before(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic calendar_result_t convert_calendar(input gdn_op_t op,
                                                          input logic [47:0] data);
        calendar_result_t res;
        int unsigned      y, m, d, dn, rem, c400, c100, c4, c1, last_day;
        y        = 32'(data[13:0]);
        m        = 32'(data[17:14]);
        d        = 32'(data[22:18]);
        dn       = 32'(data[44:23]);
        last_day = days_before(MAX_YEAR + 1);
        res      = '0;
        if (op == OP_TO_DAY_NUMBER) begin
            if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1 ||
                d > days_in_month(y, m)) begin
                res.range_error = 1'b1;
            end else begin
                rem = days_before(y) + d;
                for (int k = 1; k < m; k++) begin
                    rem += days_in_month(y, k);
                end
                res.year       = YEAR_W'(y);
                res.month      = MONTH_W'(m);
                res.day        = DAY_W'(d);
                res.day_number = DN_W'(rem);
                res.weekday    = WD_W'(rem % 7);
            end
        end else begin
            if (dn < 1 || dn > last_day) begin
                res.range_error = 1'b1;
            end else begin
                // strip whole 400, 100, 4 and 1 year cycles
                rem  = dn - 1;
                c400 = rem / 146097;
                rem  = rem % 146097;
                c100 = rem / 36524;
                if (c100 > 3) c100 = 3;
                rem -= c100 * 36524;
                c4   = rem / 1461;
                rem  = rem % 1461;
                c1   = rem / 365;
                if (c1 > 3) c1 = 3;
                rem -= c1 * 365;
                y    = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
                rem += 1;
                m    = 1;
                while (m < 12 && rem > days_in_month(y, m)) begin
                    rem -= days_in_month(y, m);
                    m++;
                end
                res.year       = YEAR_W'(y);
                res.month      = MONTH_W'(m);
                res.day        = DAY_W'(rem);
                res.day_number = DN_W'(dn);
                res.weekday    = WD_W'(dn % 7);
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        calendar_result_t want;
        calendar_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_dates.push_back(convert_calendar(gdn_op_t'(s_tuser[0]), s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.year        = m_tdata[13:0];
                got.month       = m_tdata[17:14];
                got.day         = m_tdata[22:18];
                got.day_number  = m_tdata[44:23];
                got.weekday     = m_tdata[47:45];
                got.range_error = m_tuser[0];
                if (expected_dates.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected result transaction, year %0d month %0d",
                                 $time, got.year, got.month);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year != want.year || got.month != want.month ||
                        got.day != want.day || got.day_number != want.day_number ||
                        got.weekday != want.weekday ||
                        got.range_error != want.range_error) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected y %0d m %0d d %0d dn %0d wd %0d err %0d",
                                     want.year, want.month, want.day, want.day_number,
                                     want.weekday, want.range_error);
                            $display("  actual   y %0d m %0d d %0d dn %0d wd %0d err %0d",
                                     got.year, got.month, got.day, got.day_number,
                                     got.weekday, got.range_error);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the day number converter: directed calendar corner cases,
// then random dates and day numbers with random idling on both channels and
// one long output hold-off. The checker module does the comparison.
// ----------------------------------------------------------------------------
module tb;
    import gdn_pkg::*;

    localparam int LAST_DAY     = MAX_DAY_NUMBER;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_FROM    = 1050;
    localparam int LONG_HOLD    = 100;
    localparam int IDLE_LIMIT   = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // in_year, in_month, in_day, in_day_number, zero pad
    logic [0:0]  s_tuser  = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // out_year, out_month, out_day, out_day_number, weekday
    logic [0:0]  m_tuser;         // range_error

    int failures;
    int pending;
    int idle_pct     = 20;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    gregorian_day_number_converter_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gdn_result_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // offer one transaction and hold it until accepted, then maybe idle
    task automatic offer_date(input gdn_op_t op, input int unsigned y, input int unsigned m,
                              input int unsigned d, input int unsigned dn);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, dn[21:0], d[4:0], m[3:0], y[13:0]};
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned y, m, d, dn, pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calendar corners, leap rules and range errors
        offer_date(OP_TO_DAY_NUMBER, 1, 1, 1, $urandom);
        offer_date(OP_TO_DAY_NUMBER, 9999, 12, 31, 0);
        offer_date(OP_TO_DAY_NUMBER, 2000, 2, 29, 22'h3fffff);
        offer_date(OP_TO_DAY_NUMBER, 1900, 2, 29, 0);
        offer_date(OP_TO_DAY_NUMBER, 2004, 2, 29, 0);
        offer_date(OP_TO_DAY_NUMBER, 2001, 2, 29, 0);
        offer_date(OP_TO_DAY_NUMBER, 0, 1, 1, 0);
        offer_date(OP_TO_DAY_NUMBER, 10000, 1, 1, 0);
        offer_date(OP_TO_DAY_NUMBER, 16383, 15, 31, 22'h3fffff);
        offer_date(OP_TO_DAY_NUMBER, 2024, 0, 10, 0);
        offer_date(OP_TO_DAY_NUMBER, 2024, 13, 10, 0);
        offer_date(OP_TO_DAY_NUMBER, 2024, 4, 31, 0);
        offer_date(OP_TO_DAY_NUMBER, 2024, 1, 0, 0);
        offer_date(OP_TO_DAY_NUMBER, 2024, 12, 31, 0);
        offer_date(OP_TO_DATE, 0, 0, 0, 0);
        offer_date(OP_TO_DATE, 16383, 15, 31, 1);
        offer_date(OP_TO_DATE, $urandom, $urandom, $urandom, LAST_DAY);
        offer_date(OP_TO_DATE, 0, 0, 0, LAST_DAY + 1);
        offer_date(OP_TO_DATE, 0, 0, 0, 22'h3fffff);
        offer_date(OP_TO_DATE, 0, 0, 0, 146097);
        offer_date(OP_TO_DATE, 0, 0, 0, 146096);
        offer_date(OP_TO_DATE, 0, 0, 0, 36524);
        offer_date(OP_TO_DATE, 0, 0, 0, 1461);
        offer_date(OP_TO_DATE, 0, 0, 0, 366);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= CALM_FROM) idle_pct = 0;
            else if (i % 100 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                              ($urandom_range(0, 1) ? 15 : 40);
            if (i == 400) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            y    = $urandom;
            m    = $urandom;
            d    = $urandom;
            dn   = $urandom;
            if (pick < 40) begin
                // mostly valid dates, centuries to hit the leap exceptions
                y = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(1, 99)
                                                : $urandom_range(1, MAX_YEAR);
                m = $urandom_range(1, 12);
                d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                : $urandom_range(1, 28);
                offer_date(OP_TO_DAY_NUMBER, y, m, d, dn);
            end else if (pick < 80) begin
                // land around the end of a four year group now and then
                dn = ($urandom_range(0, 3) == 0) ? 1461 * $urandom_range(1, 2499)
                                                   + $urandom_range(0, 2) - 1
                                                 : $urandom_range(1, LAST_DAY);
                offer_date(OP_TO_DATE, y, m, d, dn);
            end else if (pick < 90) begin
                offer_date(OP_TO_DAY_NUMBER, y, m, d, dn);
            end else begin
                offer_date(OP_TO_DATE, y, m, d, dn);
            end
        end
        s_tvalid <= 1'b0;
        // let the checker record the last accepted transaction
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
